// ----- sv/olid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_pkg
// Types and codes shared by the ordered list cells and the list top level.
// ----------------------------------------------------------------------------
package olid_pkg;

   localparam int WORD_W  = 32;
   localparam int POS_W   = 13;  // covers cell indexes and counts up to 4096
   localparam int REQ_W   = 3;
   localparam int REQP_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   // broadcast to every cell in the row
   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] word;
   } cell_cmd_type;

endpackage

// ----- sv/olid_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_cell
// One list entry. Takes its lower or upper neighbour's word on a shift,
// the broadcast word on a write or upward shift at its own index, and
// gates its word onto the read bus when its index is addressed.
// ----------------------------------------------------------------------------
module olid_cell #(
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  olid_pkg::cell_cmd_type             cmd,
   input  logic [olid_pkg::POS_W-1:0]         rd_pos,
   input  logic signed [olid_pkg::WORD_W-1:0] lower_word,
   input  logic signed [olid_pkg::WORD_W-1:0] upper_word,
   output logic signed [olid_pkg::WORD_W-1:0] cell_word,
   output logic signed [olid_pkg::WORD_W-1:0] rd_word
);
   import olid_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic signed [WORD_W-1:0] word_ff, word_in;
   logic                     at_pos, above_pos;

   assign at_pos    = (cmd.pos == MY_POS);
   assign above_pos = (MY_POS > cmd.pos);

   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         CELL_WRITE: begin
            if (at_pos) word_in = cmd.word;
         end
         CELL_SHIFT_UP: begin
            if (above_pos) word_in = lower_word;
            else if (at_pos) word_in = cmd.word;
         end
         CELL_SHIFT_DOWN: begin
            if (above_pos || at_pos) word_in = upper_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign cell_word = word_ff;
   assign rd_word   = (rd_pos == MY_POS) ? word_ff : '0;

endmodule

// ----- sv/ordered_list_insert_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Bounded ordered list of signed words held in a row of cells; append,
// insert, delete, replace, read and clear, one status word per request.
//
//   channel  dir  ports                                  word
//   req      in   req_valid/req_ready                    type, position, word
//   rsp      out  rsp_valid/rsp_ready                    status, word, count
//
// One request per cycle while req_ready is high: every cell shifts in the
// same edge, and the result sits in the output register in the cycle after.
// req_ready is high while the output register is empty or being drained.
// Reset clears the count and the output valid; cell contents are kept.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [olid_pkg::REQ_W-1:0]          req_type,
   input  logic [olid_pkg::REQP_W-1:0]         req_position,
   input  logic signed [olid_pkg::WORD_W-1:0]  req_word_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [olid_pkg::WORD_W-1:0]  rsp_word_out,
   output logic [olid_pkg::COUNT_W-1:0]        rsp_entry_count
);
   import olid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic signed [WORD_W-1:0] word_ff, word_in;
   logic [COUNT_W-1:0]       count_ff, count_in;

   cell_cmd_type             cmd;
   logic                     fire, full, in_range, ins_ok;
   logic [POS_W-1:0]         pos_w, cnt_w;
   logic signed [WORD_W-1:0] cell_words [CAPACITY];
   logic signed [WORD_W-1:0] rd_words   [CAPACITY];
   logic signed [WORD_W-1:0] rd_bus;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign pos_w     = POS_W'(req_position);
   assign cnt_w     = POS_W'(cnt_ff);
   assign full      = (cnt_w >= CAP_POS);
   assign in_range  = (pos_w < cnt_w);
   assign ins_ok    = !full && (pos_w <= cnt_w);

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      olid_cell #(.INDEX(k)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .rd_pos     (pos_w),
         .lower_word ((k == 0) ? cell_words[0] : cell_words[(k == 0) ? 0 : k - 1]),
         .upper_word ((k == CAPACITY - 1) ? cell_words[k]
                                          : cell_words[(k == CAPACITY - 1) ? k : k + 1]),
         .cell_word  (cell_words[k]),
         .rd_word    (rd_words[k])
      );
   end

   always_comb begin
      rd_bus = '0;
      for (int k = 0; k < CAPACITY; k++) rd_bus = rd_bus | rd_words[k];
   end

   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.pos   = pos_w;
      cmd.word  = req_word_in;
      cnt_in    = cnt_ff;
      status_in = ST_OK;
      word_in   = '0;
      if (fire) begin
         unique case (req_type)
            REQ_APPEND: begin
               if (full) status_in = ST_FULL;
               else begin
                  cmd.op  = CELL_WRITE;
                  cmd.pos = cnt_w;
                  cnt_in  = cnt_ff + 1'b1;
               end
            end
            REQ_INSERT: begin
               if (full) status_in = ST_FULL;
               else if (!ins_ok) status_in = ST_RANGE;
               else begin
                  cmd.op = CELL_SHIFT_UP;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            REQ_DELETE: begin
               if (!in_range) status_in = ST_RANGE;
               else begin
                  cmd.op = CELL_SHIFT_DOWN;
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            REQ_REPLACE: begin
               if (!in_range) status_in = ST_RANGE;
               else cmd.op = CELL_WRITE;
            end
            REQ_READ: begin
               if (!in_range) status_in = ST_RANGE;
               else word_in = rd_bus;
            end
            REQ_CLEAR: cnt_in = '0;
            default:   cnt_in = cnt_ff;
         endcase
      end
      count_in     = COUNT_W'(cnt_in);
      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         status_ff <= status_in;
         word_ff   <= word_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_word_out    = word_ff;
   assign rsp_entry_count = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      POS_W'(cnt_ff) <= CAP_POS)
      else $error("entry count beyond capacity");

   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("accepted word gave no response");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (POS_W'(cnt_ff) == CAP_POS))
      else $error("full status with room left");

   a_word_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word_out != '0) |-> (rsp_status == ST_OK))
      else $error("word returned on a failed request");

endmodule
